// ----- rtl/core/capsule_clearance_conflict_check_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Capsule clearance conflict check: assertion macros
// Clocked assertion shorthands; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CAPSULE_CLEARANCE_CONFLICT_CHECK_UNIT_MACROS_SVH
`define CAPSULE_CLEARANCE_CONFLICT_CHECK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// property that holds at every edge outside reset
`define CCC_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// property whose consequent holds in the cycle after the antecedent
`define CCC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CCC_ASSERT(name, expr, msg)
`define CCC_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ----- rtl/core/ccc_pkg.sv -----
// ----------------------------------------------------------------------------
// Capsule clearance conflict check: package
// Fixed field widths, datapath widths, opcodes and the stored entry layout.
// ----------------------------------------------------------------------------
package ccc_pkg;

  // field widths
  localparam int COORD_BITS = 24;
  localparam int SIZE_W     = 16;
  localparam int MAG_W      = SIZE_W - 1;
  localparam int OWNER_W    = 16;
  localparam int IDENT_W    = 32;
  localparam int OP_W       = 3;

  // datapath widths
  localparam int DIFF_W     = COORD_BITS + 1;     // coordinate difference
  localparam int Z_W        = COORD_BITS + 1;     // vertical bounds
  localparam int R_W        = MAG_W + 2;          // summed clearance radius
  localparam int R2_W       = 2 * R_W;
  localparam int WIDE_W     = 2 * DIFF_W;         // |dot|, dd, |cross|
  localparam int LIMB_W     = 26;
  localparam int WIDE_HI_W  = WIDE_W - LIMB_W;
  localparam int R2_HI_W    = R2_W - LIMB_W;
  localparam int MUL_W      = LIMB_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 4 * LIMB_W;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR    = 3'd0,
    OP_ADD_CELL = 3'd1,
    OP_ADD_SEG  = 3'd2,
    OP_QRY_PT   = 3'd3,
    OP_QRY_SEG  = 3'd4
  } opcode_t;

  // one stored reservation; a cell keeps its center in both ends
  typedef struct packed {
    logic [OWNER_W-1:0]           owner;
    logic [IDENT_W-1:0]           ident;
    logic signed [Z_W-1:0]        elo;
    logic signed [Z_W-1:0]        ehi;
    logic [MAG_W-1:0]             er;
    logic [MAG_W-1:0]             es;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] tx;
    logic signed [COORD_BITS-1:0] ty;
  } entry_t;

  // negative sizes count as zero
  function automatic logic [MAG_W-1:0] clamp0(input logic [SIZE_W-1:0] v);
    return v[SIZE_W-1] ? '0 : v[MAG_W-1:0];
  endfunction

endpackage

// ----- rtl/core/capsule_clearance_conflict_check_unit.sv -----
// ----------------------------------------------------------------------------
// Capsule clearance conflict check unit
// Writes and clear: the result word passes through S_FIN to the output register.
// Query: entries are screened in S_CHK; a tested cell or segment runs its
//   jobs in S_MUL; all products run through one 27x27 MAC.
// Input is stalled from acceptance until the result is in the output register.
// Sync reset empties both stores (fill counts) and the handshake; no sweep.
// ----------------------------------------------------------------------------
`include "capsule_clearance_conflict_check_unit_macros.svh"

module capsule_clearance_conflict_check_unit #(
  parameter int CELL_ENTRIES    = 32,
  parameter int SEGMENT_ENTRIES = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [ccc_pkg::OP_W-1:0]               opcode,
  input  logic [ccc_pkg::OWNER_W-1:0]            owner_tag,
  input  logic signed [ccc_pkg::COORD_BITS-1:0]  pos_a_x,
  input  logic signed [ccc_pkg::COORD_BITS-1:0]  pos_a_y,
  input  logic signed [ccc_pkg::COORD_BITS-1:0]  pos_a_z,
  input  logic signed [ccc_pkg::COORD_BITS-1:0]  pos_b_x,
  input  logic signed [ccc_pkg::COORD_BITS-1:0]  pos_b_y,
  input  logic signed [ccc_pkg::COORD_BITS-1:0]  pos_b_z,
  input  logic signed [ccc_pkg::SIZE_W-1:0]      agent_radius,
  input  logic signed [ccc_pkg::SIZE_W-1:0]      agent_height,
  input  logic signed [ccc_pkg::SIZE_W-1:0]      extra_separation,
  input  logic [ccc_pkg::IDENT_W-1:0]            cell_ident,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   conflict,
  output logic [ccc_pkg::OWNER_W-1:0]            blocking_owner,
  output logic [ccc_pkg::IDENT_W-1:0]            blocking_cell,
  output logic                                   status
);
  import ccc_pkg::*;

  localparam int CIDX_W  = (CELL_ENTRIES > 1) ? $clog2(CELL_ENTRIES) : 1;
  localparam int SIDX_W  = (SEGMENT_ENTRIES > 1) ? $clog2(SEGMENT_ENTRIES) : 1;
  localparam int CFILL_W = $clog2(CELL_ENTRIES + 1);
  localparam int SFILL_W = $clog2(SEGMENT_ENTRIES + 1);
  localparam int SCAN_W  = (CFILL_W > SFILL_W) ? CFILL_W : SFILL_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SCAN = 8'b0000_0010,
    S_CHK  = 8'b0000_0100,
    S_R2   = 8'b0000_1000,
    S_R2W  = 8'b0001_0000,
    S_JOB  = 8'b0010_0000,
    S_MUL  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  // micro steps of one job on the shared MAC
  typedef enum logic [4:0] {
    ST_O0, ST_O1, ST_OE,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5,
    ST_W0, ST_W1, ST_W2, ST_W3, ST_W4, ST_W5, ST_W6, ST_W7, ST_WE,
    ST_N0, ST_N1, ST_N2, ST_N3, ST_NE
  } step_t;

  typedef enum logic [1:0] {MAC_HOLD, MAC_LOAD, MAC_ADD, MAC_SUB} mac_op_t;
  typedef enum logic [1:0] {SH_0, SH_1, SH_2} mac_sh_t;

  state_t state;
  step_t  step;

  // stores
  entry_t cell_mem [CELL_ENTRIES];
  entry_t seg_mem  [SEGMENT_ENTRIES];
  entry_t cell_rd, seg_rd, ent_sel, wr_ent;
  logic [CFILL_W-1:0] cell_fill;
  logic [SFILL_W-1:0] seg_fill;
  logic cell_we, seg_we, cell_full, seg_full, accept;

  // query context
  logic [OWNER_W-1:0]           qowner;
  logic signed [COORD_BITS-1:0] qax, qay, qbx, qby;
  logic [MAG_W-1:0]             qr, qs;
  logic signed [Z_W-1:0]        qlo, qhi;

  // scan and entry context
  logic [SCAN_W-1:0]            idx;
  logic                         seg_phase;
  logic [2:0]                   job;
  logic [1:0]                   osg [4];
  logic [OWNER_W-1:0]           eowner;
  logic [IDENT_W-1:0]           eident;
  logic signed [COORD_BITS-1:0] esx, esy, etx, ety;
  logic [R_W-1:0]               rsum;
  logic [R2_W-1:0]              r2;

  // job operands and saved intermediates
  logic signed [DIFF_W-1:0]     wx, wy, dx, dy, ex, ey;
  logic signed [WIDE_W:0]       dot;
  logic [WIDE_W-1:0]            dd, cr;
  logic signed [ACC_W-1:0]      acc, acc_next, addend;
  logic signed [MUL_W-1:0]      ma, mb;
  logic signed [PROD_W-1:0]     prod;
  mac_op_t                      mop;
  mac_sh_t                      msh;
  logic acc_neg, acc_zero, p2_go, p4_go, seg_cross, skip;

  // result word waiting for the output register
  logic                         res_conflict, res_status;
  logic [OWNER_W-1:0]           res_owner;
  logic [IDENT_W-1:0]           res_cell;
  logic                         out_free;

  // entry built from the input word (also gives query bounds)
  logic signed [COORD_BITS-1:0] bx_e, by_e, bz_e, zmin, zmax;
  logic [MAG_W-1:0]             h_c;
  logic                         is_seg_op;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    is_seg_op = (opcode == OP_ADD_SEG) || (opcode == OP_QRY_SEG);
    bx_e      = is_seg_op ? pos_b_x : pos_a_x;
    by_e      = is_seg_op ? pos_b_y : pos_a_y;
    bz_e      = is_seg_op ? pos_b_z : pos_a_z;
    zmin      = (pos_a_z < bz_e) ? pos_a_z : bz_e;
    zmax      = (pos_a_z > bz_e) ? pos_a_z : bz_e;
    h_c       = clamp0(agent_height);
    wr_ent.owner = owner_tag;
    wr_ent.ident = cell_ident;
    wr_ent.elo   = {zmin[COORD_BITS-1], zmin};
    wr_ent.ehi   = {zmax[COORD_BITS-1], zmax} + signed'({{(Z_W-MAG_W){1'b0}}, h_c});
    wr_ent.er    = clamp0(agent_radius);
    wr_ent.es    = clamp0(extra_separation);
    wr_ent.sx    = pos_a_x;
    wr_ent.sy    = pos_a_y;
    wr_ent.tx    = bx_e;
    wr_ent.ty    = by_e;
  end

  assign cell_full = (cell_fill >= CFILL_W'(CELL_ENTRIES));
  assign seg_full  = (seg_fill >= SFILL_W'(SEGMENT_ENTRIES));
  assign cell_we   = accept && (opcode == OP_ADD_CELL) && !cell_full;
  assign seg_we    = accept && (opcode == OP_ADD_SEG) && !seg_full;

  // store write at the fill point, registered read at the scan index
  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_fill[CIDX_W-1:0]] <= wr_ent;
    cell_rd <= cell_mem[idx[CIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (seg_we) seg_mem[seg_fill[SIDX_W-1:0]] <= wr_ent;
    seg_rd <= seg_mem[idx[SIDX_W-1:0]];
  end

  // owner and vertical screen of the entry just read
  always_comb begin
    ent_sel = seg_phase ? seg_rd : cell_rd;
    skip = (ent_sel.owner == '0) || (ent_sel.owner == qowner) ||
           !((qlo < ent_sel.ehi) && (ent_sel.elo < qhi));
  end

  // shared MAC: operand select
  always_comb begin
    ma  = '0;
    mb  = '0;
    mop = MAC_HOLD;
    msh = SH_0;
    if (state == S_R2) begin
      ma  = signed'({{(MUL_W-R_W){1'b0}}, rsum});
      mb  = signed'({{(MUL_W-R_W){1'b0}}, rsum});
      mop = MAC_LOAD;
    end else if (state == S_MUL) begin
      case (step)
        ST_O0: begin ma = MUL_W'(wx); mb = MUL_W'(dy); mop = MAC_LOAD; end
        ST_O1: begin ma = MUL_W'(wy); mb = MUL_W'(dx); mop = MAC_SUB; end
        ST_P0: begin ma = MUL_W'(wx); mb = MUL_W'(dx); mop = MAC_LOAD; end
        ST_P1: begin ma = MUL_W'(wy); mb = MUL_W'(dy); mop = MAC_ADD; end
        ST_P2: begin
          ma  = MUL_W'(dx);
          mb  = MUL_W'(dx);
          mop = p2_go ? MAC_LOAD : MAC_HOLD;
        end
        ST_P3: begin ma = MUL_W'(dy); mb = MUL_W'(dy); mop = MAC_ADD; end
        ST_P4: begin
          ma  = MUL_W'(wx);
          mb  = MUL_W'(dy);
          mop = p4_go ? MAC_LOAD : MAC_HOLD;
        end
        ST_P5: begin ma = MUL_W'(wy); mb = MUL_W'(dx); mop = MAC_SUB; end
        // dd * r2 - cr * cr by limbs
        ST_W0: begin
          ma  = signed'({{(MUL_W-WIDE_HI_W){1'b0}}, dd[WIDE_W-1:LIMB_W]});
          mb  = signed'({{(MUL_W-R2_HI_W){1'b0}}, r2[R2_W-1:LIMB_W]});
          mop = MAC_LOAD;
          msh = SH_2;
        end
        ST_W1: begin
          ma  = signed'({{(MUL_W-WIDE_HI_W){1'b0}}, dd[WIDE_W-1:LIMB_W]});
          mb  = signed'({1'b0, r2[LIMB_W-1:0]});
          mop = MAC_ADD;
          msh = SH_1;
        end
        ST_W2: begin
          ma  = signed'({1'b0, dd[LIMB_W-1:0]});
          mb  = signed'({{(MUL_W-R2_HI_W){1'b0}}, r2[R2_W-1:LIMB_W]});
          mop = MAC_ADD;
          msh = SH_1;
        end
        ST_W3: begin
          ma  = signed'({1'b0, dd[LIMB_W-1:0]});
          mb  = signed'({1'b0, r2[LIMB_W-1:0]});
          mop = MAC_ADD;
        end
        ST_W4: begin
          ma  = signed'({{(MUL_W-WIDE_HI_W){1'b0}}, cr[WIDE_W-1:LIMB_W]});
          mb  = signed'({{(MUL_W-WIDE_HI_W){1'b0}}, cr[WIDE_W-1:LIMB_W]});
          mop = MAC_SUB;
          msh = SH_2;
        end
        ST_W5, ST_W6: begin
          ma  = signed'({{(MUL_W-WIDE_HI_W){1'b0}}, cr[WIDE_W-1:LIMB_W]});
          mb  = signed'({1'b0, cr[LIMB_W-1:0]});
          mop = MAC_SUB;
          msh = SH_1;
        end
        ST_W7: begin
          ma  = signed'({1'b0, cr[LIMB_W-1:0]});
          mb  = signed'({1'b0, cr[LIMB_W-1:0]});
          mop = MAC_SUB;
        end
        // squared endpoint distance minus r2
        ST_N0: begin ma = MUL_W'(ex); mb = MUL_W'(ex); mop = MAC_LOAD; end
        ST_N1: begin ma = MUL_W'(ey); mb = MUL_W'(ey); mop = MAC_ADD; end
        ST_N2: begin
          ma  = signed'({1'b0, r2[LIMB_W-1:0]});
          mb  = MUL_W'(1);
          mop = MAC_SUB;
        end
        ST_N3: begin
          ma  = signed'({{(MUL_W-R2_HI_W){1'b0}}, r2[R2_W-1:LIMB_W]});
          mb  = MUL_W'(1);
          mop = MAC_SUB;
          msh = SH_1;
        end
        default: mop = MAC_HOLD;
      endcase
    end
  end

  // shared MAC: multiply, align, accumulate
  always_comb begin
    prod = ma * mb;
    case (msh)
      SH_1:    addend = ACC_W'(prod) <<< LIMB_W;
      SH_2:    addend = ACC_W'(prod) <<< (2 * LIMB_W);
      default: addend = ACC_W'(prod);
    endcase
    case (mop)
      MAC_LOAD: acc_next = addend;
      MAC_ADD:  acc_next = acc + addend;
      MAC_SUB:  acc_next = acc - addend;
      default:  acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  // decisions on the registered accumulator
  assign acc_neg   = acc[ACC_W-1];
  assign acc_zero  = (acc == '0);
  assign p2_go     = !acc_neg && !acc_zero;
  assign p4_go     = (dot[WIDE_W-1:0] < acc[WIDE_W-1:0]);
  assign seg_cross = ((osg[0][1] && osg[1][0]) || (osg[0][0] && osg[1][1])) &&
                     ((osg[2][1] && !acc_neg && !acc_zero) || (osg[2][0] && acc_neg));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cell_fill <= '0;
      seg_fill  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_FIN)) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_conflict <= 1'b0;
            res_owner    <= '0;
            res_cell     <= '0;
            res_status   <= ((opcode == OP_ADD_CELL) && cell_full) ||
                            ((opcode == OP_ADD_SEG) && seg_full);
            qowner       <= owner_tag;
            qax          <= pos_a_x;
            qay          <= pos_a_y;
            qbx          <= bx_e;
            qby          <= by_e;
            qr           <= wr_ent.er;
            qs           <= wr_ent.es;
            qlo          <= wr_ent.elo;
            qhi          <= wr_ent.ehi;
            idx          <= '0;
            seg_phase    <= 1'b0;
            case (opcode)
              OP_CLEAR: begin
                cell_fill <= '0;
                seg_fill  <= '0;
                state     <= S_FIN;
              end
              OP_ADD_CELL: begin
                if (!cell_full) cell_fill <= cell_fill + 1'b1;
                state <= S_FIN;
              end
              OP_ADD_SEG: begin
                if (!seg_full) seg_fill <= seg_fill + 1'b1;
                state <= S_FIN;
              end
              OP_QRY_PT, OP_QRY_SEG: state <= S_SCAN;
              default: state <= S_FIN;
            endcase
          end
        end

        // cells first, then segments
        S_SCAN: begin
          if (!seg_phase) begin
            if (idx < SCAN_W'(cell_fill)) begin
              state <= S_CHK;
            end else begin
              seg_phase <= 1'b1;
              idx       <= '0;
            end
          end else if (idx < SCAN_W'(seg_fill)) begin
            state <= S_CHK;
          end else begin
            state <= S_FIN;
          end
        end

        S_CHK: begin
          eowner <= ent_sel.owner;
          eident <= ent_sel.ident;
          esx    <= ent_sel.sx;
          esy    <= ent_sel.sy;
          etx    <= ent_sel.tx;
          ety    <= ent_sel.ty;
          rsum   <= R_W'(qr) + R_W'(ent_sel.er) +
                    R_W'((qs > ent_sel.es) ? qs : ent_sel.es);
          if (skip) begin
            idx   <= idx + 1'b1;
            state <= S_SCAN;
          end else begin
            state <= S_R2;
          end
        end

        S_R2: state <= S_R2W;

        S_R2W: begin
          r2    <= acc[R2_W-1:0];
          job   <= seg_phase ? 3'd0 : 3'd6;
          state <= S_JOB;
        end

        // pick point P and segment A-B for this job
        S_JOB: begin
          if (job[2] == job[1]) begin
            wx <= DIFF_W'(job[0] ? etx : esx) - DIFF_W'(qax);
            wy <= DIFF_W'(job[0] ? ety : esy) - DIFF_W'(qay);
            dx <= DIFF_W'(qbx) - DIFF_W'(qax);
            dy <= DIFF_W'(qby) - DIFF_W'(qay);
          end else begin
            wx <= DIFF_W'(job[0] ? qbx : qax) - DIFF_W'(esx);
            wy <= DIFF_W'(job[0] ? qby : qay) - DIFF_W'(esy);
            dx <= DIFF_W'(etx) - DIFF_W'(esx);
            dy <= DIFF_W'(ety) - DIFF_W'(esy);
          end
          step  <= job[2] ? ST_P0 : ST_O0;
          state <= S_MUL;
        end

        S_MUL: begin
          case (step)
            ST_OE: begin
              osg[job[1:0]] <= {acc_neg, !acc_neg && !acc_zero};
              if (job == 3'd3 && seg_cross) begin
                if (r2 != '0) begin
                  res_conflict <= 1'b1;
                  res_owner    <= eowner;
                  res_cell     <= eident;
                  state        <= S_FIN;
                end else begin
                  idx   <= idx + 1'b1;
                  state <= S_SCAN;
                end
              end else begin
                job   <= job + 1'b1;
                state <= S_JOB;
              end
            end
            ST_P2: begin
              dot <= acc[WIDE_W:0];
              if (p2_go) begin
                step <= ST_P3;
              end else begin
                ex   <= wx;
                ey   <= wy;
                step <= ST_N0;
              end
            end
            ST_P4: begin
              dd <= acc[WIDE_W-1:0];
              if (p4_go) begin
                step <= ST_P5;
              end else begin
                ex   <= wx - dx;
                ey   <= wy - dy;
                step <= ST_N0;
              end
            end
            ST_W0: begin
              cr   <= acc_neg ? WIDE_W'(-acc) : acc[WIDE_W-1:0];
              step <= ST_W1;
            end
            ST_WE, ST_NE: begin
              if ((step == ST_WE) ? (!acc_neg && !acc_zero) : acc_neg) begin
                res_conflict <= 1'b1;
                res_owner    <= eowner;
                res_cell     <= eident;
                state        <= S_FIN;
              end else if (!seg_phase || job == 3'd7) begin
                idx   <= idx + 1'b1;
                state <= S_SCAN;
              end else begin
                job   <= job + 1'b1;
                state <= S_JOB;
              end
            end
            ST_P5:   step <= ST_W0;
            ST_N3:   step <= ST_NE;
            default: step <= step_t'(step + 1'b1);
          endcase
        end

        S_FIN: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            conflict       <= res_conflict;
            blocking_owner <= res_owner;
            blocking_cell  <= res_cell;
            status         <= res_status;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `CCC_ASSERT(a_fill_bound, (cell_fill <= CFILL_W'(CELL_ENTRIES)) && (seg_fill <= SFILL_W'(SEGMENT_ENTRIES)), "fill count past store depth")
  `CCC_ASSERT(a_scan_bound, (state != S_CHK) || (seg_phase ? (idx < SCAN_W'(seg_fill)) : (idx < SCAN_W'(cell_fill))), "entry check beyond fill")
  `CCC_ASSERT(a_hit_owner, !(out_valid && conflict) || ((blocking_owner != '0) && !status), "conflict without valid owner")
  `CCC_ASSERT(a_drop_clean, !(out_valid && status) || (!conflict && (blocking_owner == '0)), "dropped write carries a blocker")
  `CCC_ASSERT_NEXT(a_busy_after_take, accept, in_stall, "input taken twice in a row")

endmodule
